// ===== rtl/hourly_minmax_recorder_core_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef HOURLY_MINMAX_RECORDER_CORE_DEFINES_SVH
`define HOURLY_MINMAX_RECORDER_CORE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define HMR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define HMR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hmr_pkg.sv =====
`default_nettype none

package hmr_pkg;

    localparam int BINS     = 24;
    localparam int IDX_W    = $clog2(BINS);
    localparam int TEMP_W   = 12;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;

    localparam logic [MIN_W-1:0] RESTART_RESET = MIN_W'(2);

    // One hour bin: lowest and highest temperature seen.
    typedef struct packed {
        logic signed [TEMP_W-1:0] low;
        logic signed [TEMP_W-1:0] high;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/hmr_channels.sv =====
`default_nettype none

// Sample channel: one temperature word tagged with hour and minute.
interface hmr_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hmr_pkg::TEMP_W-1:0]    temperature;
    logic        [hmr_pkg::HOUR_W-1:0]    hour_of_day;
    logic        [hmr_pkg::MIN_W-1:0]     minute_of_hour;

    modport source (output valid, temperature, hour_of_day, minute_of_hour, input ready);
    modport sink   (input valid, temperature, hour_of_day, minute_of_hour, output ready);
endinterface

// Result channel: overall min and max over all bins.
interface hmr_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hmr_pkg::TEMP_W-1:0]    overall_min;
    logic signed [hmr_pkg::TEMP_W-1:0]    overall_max;

    modport source (output valid, overall_min, overall_max, input ready);
    modport sink   (input valid, overall_min, overall_max, output ready);
endinterface

// Configuration channel: restart threshold write.
interface hmr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic        [hmr_pkg::MIN_W-1:0]     restart_minutes;

    modport source (output valid, restart_minutes, input ready);
    modport sink   (input valid, restart_minutes, output ready);
endinterface

`default_nettype wire

// ===== rtl/hmr_cell.sv =====
`default_nettype none

// One ring cell: holds a bin, passes it on to its neighbor on each shift.
module hmr_cell (
    input  wire logic            i_clk,
    input  wire logic            i_shift,
    input  wire hmr_pkg::t_entry i_entry,
    output hmr_pkg::t_entry      o_entry
);

    hmr_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ===== rtl/hourly_minmax_recorder_core.sv =====
//  channel   | dir | modport | word contents
//  ----------+-----+---------+--------------------------------------------
//  i_sample  | in  | sink    | temperature, hour_of_day, minute_of_hour
//  o_result  | out | source  | overall_min, overall_max
//  i_cfg     | in  | sink    | restart_minutes (always ready)
//
//  Steps per sample: accept, one ring shift per cell, then load the result
//  register. The 24-cell ring turns once per sample; bin count sets it.
//  Reset: synchronous, active low; clears control, threshold back to 2,
//  bins unseeded. Bin contents are not reset; the first sample fills them all.
//  Stalls: a result waits in its register; the next sample is taken meanwhile,
//  and its sweep holds in the final step until the result register frees up.
`default_nettype none
`include "hourly_minmax_recorder_core_defines.svh"

module hourly_minmax_recorder_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hmr_sample_if.sink  i_sample,
    hmr_result_if.source o_result,
    hmr_cfg_if.sink     i_cfg
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_PUSH
    } t_state;

    localparam logic [hmr_pkg::IDX_W-1:0] IDX_LAST = hmr_pkg::IDX_W'(hmr_pkg::BINS - 1);

    // control
    t_state                         r_state,     n_state;
    logic [hmr_pkg::IDX_W-1:0]      r_idx,       n_idx;
    logic                           r_seeded,    n_seeded;
    logic                           r_out_valid, n_out_valid;
    logic [hmr_pkg::MIN_W-1:0]      r_restart,   n_restart;

    // payload
    logic signed [hmr_pkg::TEMP_W-1:0] r_temp;
    logic        [hmr_pkg::HOUR_W-1:0] r_hour;
    logic        [hmr_pkg::MIN_W-1:0]  r_minute;
    hmr_pkg::t_entry                   r_acc, n_acc;
    hmr_pkg::t_entry                   r_out;

    // ring
    hmr_pkg::t_entry w_cell [hmr_pkg::BINS];
    hmr_pkg::t_entry w_upd;
    logic            w_shift;
    logic            w_take;
    logic            w_out_free;

    assign w_take     = i_sample.valid && i_sample.ready;
    assign w_shift    = (r_state == ST_SWEEP);
    assign w_out_free = !r_out_valid || o_result.ready;

    // Ring of cells: bin at cell 0 passes through the update, re-enters at the tail.
    for (genvar k = 0; k < hmr_pkg::BINS; k++) begin : g_ring
        if (k == hmr_pkg::BINS - 1) begin : g_tail
            hmr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_upd),
                .o_entry (w_cell[k])
            );
        end else begin : g_body
            hmr_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_cell[k+1]),
                .o_entry (w_cell[k])
            );
        end
    end

    // Head update: r_idx names the bin currently at cell 0.
    always_comb begin
        w_upd = w_cell[0];
        if (!r_seeded) begin
            w_upd.low  = r_temp;
            w_upd.high = r_temp;
        end else if (r_idx == hmr_pkg::IDX_W'(r_hour)) begin
            if (r_minute < r_restart) begin
                w_upd.low  = r_temp;
                w_upd.high = r_temp;
            end else if (r_temp < w_cell[0].low) begin
                w_upd.low  = r_temp;
            end else if (r_temp > w_cell[0].high) begin
                w_upd.high = r_temp;
            end
        end
    end

    // Running min/max over updated bins.
    always_comb begin
        n_acc = r_acc;
        if (w_shift) begin
            if (r_idx == '0) begin
                n_acc = w_upd;
            end else begin
                if (w_upd.low < r_acc.low) begin
                    n_acc.low = w_upd.low;
                end
                if (w_upd.high > r_acc.high) begin
                    n_acc.high = w_upd.high;
                end
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_seeded    = r_seeded;
        n_out_valid = r_out_valid;
        n_restart   = r_restart;

        if (i_cfg.valid && i_cfg.ready) begin
            n_restart = i_cfg.restart_minutes;
        end
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = ST_SWEEP;
                    n_idx   = '0;
                end
            end
            ST_SWEEP: begin
                n_idx = r_idx + hmr_pkg::IDX_W'(1);
                if (r_idx == IDX_LAST) begin
                    n_state  = ST_PUSH;
                    n_idx    = '0;
                    n_seeded = 1'b1;
                end
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_restart   <= hmr_pkg::RESTART_RESET;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
            r_restart   <= n_restart;
            if (r_state == ST_PUSH && w_out_free) begin
                r_out <= r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_temp   <= i_sample.temperature;
            r_hour   <= i_sample.hour_of_day;
            r_minute <= i_sample.minute_of_hour;
        end
        r_acc <= n_acc;
    end

    assign i_sample.ready       = (r_state == ST_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_result.valid       = r_out_valid;
    assign o_result.overall_min = r_out.low;
    assign o_result.overall_max = r_out.high;

    `HMR_ASSERT_NEXT(a_take_starts_sweep, w_take,
        (r_state == ST_SWEEP) && (r_idx == '0), "sample word did not start a sweep")
    `HMR_ASSERT_NEXT(a_sweep_ends, (r_state == ST_SWEEP) && (r_idx == IDX_LAST),
        (r_state == ST_PUSH) && r_seeded, "sweep did not end after last bin")
    `HMR_ASSERT_NEXT(a_push_loads, (r_state == ST_PUSH) && w_out_free,
        r_out_valid && (r_state == ST_IDLE), "result word not loaded")
    `HMR_ASSERT_NOW(a_acc_ordered, r_state == ST_PUSH,
        r_acc.low <= r_acc.high, "overall min above overall max")

endmodule

`default_nettype wire

// ===== verif/hourly_minmax_recorder_core_test.sv =====
// Hourly min/max recorder: stimulus, prediction and checking.
//
// One sample word in gives one result word out. Every accepted sample is run
// through a local copy of the bin store and the restart threshold. The
// overall low/high it yields is queued, and each result word is checked
// against the oldest queued pair.
//
// Register writes are made only with the block drained. That means no sample
// is queued or in flight, no result is due, and the SETTLE wait has passed.
module hourly_minmax_recorder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word moving on any channel before the run is called dead.
    // The worst legit gap is the long result hold plus a sweep.
    localparam int QUIET_LIMIT  = 2000;
    // Longer than a sweep; waited out before touching the register.
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 40;   // results seen before the long hold
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 125;
    localparam int QUIET_PHASES = 2;    // last phases run with no idling

    typedef struct packed {
        logic signed [hmr_pkg::TEMP_W-1:0] temperature;
        logic        [hmr_pkg::HOUR_W-1:0] hour;
        logic        [hmr_pkg::MIN_W-1:0]  minute;
    } t_reading;

    logic i_clk;
    logic i_rst_n;

    hmr_sample_if sample_bus ();
    hmr_result_if result_bus ();
    hmr_cfg_if    cfg_bus ();

    hourly_minmax_recorder_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Local copy of the recorder state. Set up at the start, then only the monitor touches it.
    // ------------------------------------------------------------------
    logic signed [hmr_pkg::TEMP_W-1:0] bin_floor [hmr_pkg::BINS];
    logic signed [hmr_pkg::TEMP_W-1:0] bin_peak  [hmr_pkg::BINS];
    logic                              bins_seeded;
    logic        [hmr_pkg::MIN_W-1:0]  restart_threshold;

    t_reading        pending_readings [$];  // words not yet offered
    hmr_pkg::t_entry extremes_due [$];      // overall low/high still owed
    int              readings_issued;
    int              readings_accepted;
    int              results_seen;
    int              thresholds_taken;
    int              mismatches;

    logic            sample_taken;          // word accepted at the last edge
    logic            idle_mode;
    int              send_gap;
    int              stall_left;
    int              hold_left;
    logic            long_hold_done;
    int              quiet_cycles;
    t_reading        staged_word;

    // Random walk of a wall clock, plus a temperature band per phase, so half the
    // samples look like real minute-by-minute readings.
    int              walk_hour;
    int              walk_minute;
    int              band_center;

    // Folds one sample into the bins and returns the overall low/high.
    // First sample after reset seeds every bin, even with a bad hour.
    // Hours past the last bin touch nothing. Minute below the threshold
    // restarts the bin; otherwise it's a plain min/max update.
    function automatic hmr_pkg::t_entry record_sample(
        input logic signed [hmr_pkg::TEMP_W-1:0] temp,
        input logic        [hmr_pkg::HOUR_W-1:0] hour,
        input logic        [hmr_pkg::MIN_W-1:0]  minute);
        hmr_pkg::t_entry span;
        if (!bins_seeded) begin
            bins_seeded = 1'b1;
            for (int i = 0; i < hmr_pkg::BINS; i++) begin
                bin_floor[i] = temp;
                bin_peak[i]  = temp;
            end
        end else if (hour < hmr_pkg::BINS) begin
            if (minute < restart_threshold) begin
                bin_floor[hour] = temp;
                bin_peak[hour]  = temp;
            end else if (temp < bin_floor[hour]) begin
                bin_floor[hour] = temp;
            end else if (temp > bin_peak[hour]) begin
                bin_peak[hour] = temp;
            end
        end
        span.low  = bin_floor[0];
        span.high = bin_peak[0];
        for (int i = 1; i < hmr_pkg::BINS; i++) begin
            if (bin_floor[i] < span.low)
                span.low = bin_floor[i];
            if (bin_peak[i] > span.high)
                span.high = bin_peak[i];
        end
        return span;
    endfunction

    task automatic report_mismatch(input string note);
        mismatches++;
        $display("mismatch at %0t: result word %0d: %s", $realtime, results_seen, note);
    endtask

    task automatic queue_reading(input int temp, input int hour, input int minute);
        t_reading r;
        r.temperature = hmr_pkg::TEMP_W'(temp);
        r.hour        = hmr_pkg::HOUR_W'(hour);
        r.minute      = hmr_pkg::MIN_W'(minute);
        pending_readings.push_back(r);
        readings_issued++;
    endtask

    // Half clock walk, a third scattered in range, the rest with a chance of bad hours or
    // minutes. Temperatures mostly hug the phase band so bins actually move.
    task automatic queue_random_reading();
        int pick;
        int t;
        int h;
        int m;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            walk_minute += $urandom_range(1, 12);
            if (walk_minute >= 60) begin
                walk_minute -= 60;
                walk_hour = (walk_hour + 1) % hmr_pkg::BINS;
            end
            h = walk_hour;
            m = walk_minute;
        end else if (pick < 85) begin
            h = $urandom_range(0, hmr_pkg::BINS - 1);
            m = $urandom_range(0, 59);
        end else begin
            h = $urandom_range(0, 1) ? $urandom_range(hmr_pkg::BINS, 31)
                                     : $urandom_range(0, hmr_pkg::BINS - 1);
            m = $urandom_range(0, 63);
        end
        pick = $urandom_range(0, 99);
        if (pick < 75)
            t = band_center + int'($urandom_range(0, 160)) - 80;
        else if (pick < 93)
            t = int'($urandom_range(0, 4095)) - 2048;
        else
            t = $urandom_range(0, 1) ? 2047 : -2048;
        if (t > 2047)
            t = 2047;
        if (t < -2048)
            t = -2048;
        queue_reading(t, h, m);
    endtask

    // Block is drained once every queued word is in and every result is out; then waits out SETTLE.
    task automatic wait_drained();
        while (readings_accepted != readings_issued || extremes_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_threshold(input logic [hmr_pkg::MIN_W-1:0] value);
        int seen;
        seen = thresholds_taken;
        cfg_bus.restart_minutes <= value;
        cfg_bus.valid           <= 1'b1;
        do
            @(negedge i_clk);
        while (thresholds_taken == seen);
        cfg_bus.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sample driver: offers queued words at the falling edge, holds a word
    // until it is taken, and throws in idle bursts when allowed.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!sample_bus.valid || sample_taken) begin
                if (send_gap != 0) begin
                    sample_bus.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_readings.size() == 0) begin
                    sample_bus.valid <= 1'b0;
                end else if (idle_mode && $urandom_range(0, 9) == 0) begin
                    // idle burst: this cycle plus send_gap more, drawn here
                    sample_bus.valid <= 1'b0;
                    send_gap <= $urandom_range(0, 18);
                end else begin
                    staged_word = pending_readings.pop_front();
                    sample_bus.valid          <= 1'b1;
                    sample_bus.temperature    <= staged_word.temperature;
                    sample_bus.hour_of_day    <= staged_word.hour;
                    sample_bus.minute_of_hour <= staged_word.minute;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall bursts, plus one long hold-off early in
    // the run so the block fills its result register and backs up the input.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            result_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            result_bus.ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            long_hold_done <= 1'b1;
        end else if (stall_left != 0) begin
            result_bus.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_mode && $urandom_range(0, 9) == 0) begin
            result_bus.ready <= 1'b0;
            stall_left <= $urandom_range(0, 18);
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled on the rising edge. Results are checked
    // before this edge's sample is folded in, so a result can never pair up
    // with a word accepted in the same cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        hmr_pkg::t_entry want;
        sample_taken <= i_rst_n && sample_bus.valid && sample_bus.ready;
        if (i_rst_n) begin
            if (result_bus.valid && result_bus.ready) begin
                if (extremes_due.size() == 0) begin
                    report_mismatch("result word with no sample outstanding");
                end else begin
                    want = extremes_due.pop_front();
                    if (result_bus.overall_min !== want.low)
                        report_mismatch($sformatf("overall_min got %0d expected %0d",
                                                  result_bus.overall_min, want.low));
                    if (result_bus.overall_max !== want.high)
                        report_mismatch($sformatf("overall_max got %0d expected %0d",
                                                  result_bus.overall_max, want.high));
                end
                results_seen <= results_seen + 1;
            end
            if (sample_bus.valid && sample_bus.ready) begin
                extremes_due.push_back(record_sample(sample_bus.temperature,
                                                     sample_bus.hour_of_day,
                                                     sample_bus.minute_of_hour));
                readings_accepted <= readings_accepted + 1;
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                restart_threshold = cfg_bus.restart_minutes;
                thresholds_taken <= thresholds_taken + 1;
            end
        end
    end

    // Watchdog: counts cycles in which no word moves on any channel.
    always @(posedge i_clk) begin
        if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed corner cases at the reset threshold, then
    // random phases, each behind its own threshold setting.
    // ------------------------------------------------------------------
    initial begin
        i_clk                     = 1'b0;
        i_rst_n                   = 1'b0;
        sample_bus.valid          = 1'b0;
        sample_bus.temperature    = '0;
        sample_bus.hour_of_day    = '0;
        sample_bus.minute_of_hour = '0;
        result_bus.ready          = 1'b0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.restart_minutes   = '0;
        bins_seeded               = 1'b0;
        restart_threshold         = hmr_pkg::RESTART_RESET;
        readings_issued           = 0;
        readings_accepted         = 0;
        results_seen              = 0;
        thresholds_taken          = 0;
        mismatches                = 0;
        sample_taken              = 1'b0;
        idle_mode                 = 1'b1;
        send_gap                  = 0;
        stall_left                = 0;
        hold_left                 = 0;
        long_hold_done            = 1'b0;
        quiet_cycles              = 0;
        walk_hour                 = 0;
        walk_minute               = 0;
        band_center               = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, threshold still at its reset value of 2.
        queue_reading(5, 31, 40);           // first word, bad hour: still seeds all bins
        queue_reading(-2048, 0, 30);        // most negative lowers bin 0
        queue_reading(2047, 23, 59);        // most positive raises the last bin
        queue_reading(100, 24, 0);          // first bad hour: no bin touched
        queue_reading(-7, 31, 63);          // top hour and minute, ignored
        queue_reading(3, 0, 0);             // minute 0 restarts bin 0
        queue_reading(-1, 23, 1);           // just under the threshold: restart
        queue_reading(-20, 23, 2);          // equal to the threshold: plain update
        queue_reading(1000, 12, 60);        // minute past 59, compared as is
        queue_reading(-1000, 12, 63);
        queue_reading(5, 5, 10);            // equal to bin contents, no change
        queue_reading(12'h555, 16, 21);     // alternating bit patterns
        queue_reading(-1366, 15, 42);       // 12'haaa
        queue_reading(0, 8, 21);
        queue_reading(0, 7, 0);
        queue_reading(-2048, 10, 59);
        queue_reading(2047, 10, 1);         // restart wipes the low just written
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_threshold(hmr_pkg::MIN_W'(0));    // nothing restarts
                1: set_threshold(hmr_pkg::MIN_W'(63));   // every minute below 63 restarts
                2: set_threshold(hmr_pkg::MIN_W'(60));
                3: set_threshold(hmr_pkg::MIN_W'(59));
                4: set_threshold(hmr_pkg::MIN_W'(1));
                5: set_threshold(hmr_pkg::MIN_W'($urandom_range(0, 63)));
                6: set_threshold(hmr_pkg::MIN_W'(30));
                default: set_threshold(hmr_pkg::RESTART_RESET);
            endcase
            // idling on every other phase, none at all in the closing phases
            idle_mode   <= (phase < PHASES - QUIET_PHASES) && (phase % 2 == 0);
            band_center = int'($urandom_range(0, 3600)) - 1800;
            for (int k = 0; k < PHASE_WORDS; k++)
                queue_random_reading();
            wait_drained();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hmr_pkg.sv
rtl/hmr_channels.sv
rtl/hmr_cell.sv
rtl/hourly_minmax_recorder_core.sv
verif/hourly_minmax_recorder_core_test.sv
